// ===== rtl/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types, constants and helper functions for the grid path search block.
// ----------------------------------------------------------------------------
package gasp_pkg;

  // Map geometry follows the 6-bit coordinate fields.
  localparam int XW    = 6;
  localparam int IW    = 2 * XW;
  localparam int CELLS = 1 << IW;
  localparam int LW    = IW + 1;
  localparam int GW    = 16;
  localparam int HW    = 10;
  localparam int FW    = GW + 1;

  // Step costs and register reset value.
  localparam logic [HW-1:0] COST_STRAIGHT = HW'(10);
  localparam logic [HW-1:0] COST_DIAG     = HW'(14);
  localparam logic [LW-1:0] LIMIT_RST     = LW'(2000);

  // Operation codes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] RS_DONE   = 2'd0;
  localparam logic [1:0] RS_FOUND  = 2'd1;
  localparam logic [1:0] RS_NOPATH = 2'd2;
  localparam logic [1:0] RS_RANGE  = 2'd3;

  // Node status codes.
  localparam logic [1:0] NS_NONE   = 2'd0;
  localparam logic [1:0] NS_OPEN   = 2'd1;
  localparam logic [1:0] NS_CLOSED = 2'd2;

  // Signed offsets in eight bits.
  localparam logic [7:0] OFS_POS  = 8'h01;
  localparam logic [7:0] OFS_ZERO = 8'h00;
  localparam logic [7:0] OFS_NEG  = 8'hFF;

  typedef struct packed {
    logic [1:0]    op;
    logic [XW-1:0] cell_x;
    logic [XW-1:0] cell_y;
    logic [XW-1:0] target_x;
    logic [XW-1:0] target_y;
    logic          walkable;
    logic [IW-1:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [LW-1:0] path_length;
    logic [LW-1:0] iterations_used;
    logic [XW-1:0] step_x;
    logic [XW-1:0] step_y;
  } out_item_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_CLR_MAP,
    UOP_LATCH,
    UOP_MAP_WR,
    UOP_SRCH_INIT,
    UOP_CLR_STAT,
    UOP_INS_START,
    UOP_SCAN_INIT,
    UOP_SCAN_RD_LIST,
    UOP_SCAN_RD_NODE,
    UOP_SCAN_CMP,
    UOP_POP_RD,
    UOP_POP_WR,
    UOP_NB_RD1,
    UOP_NB_RD2,
    UOP_NB_RD3,
    UOP_NB_RD4,
    UOP_NB_ACT,
    UOP_NB_SKIP,
    UOP_ITER_INC,
    UOP_TR_WR,
    UOP_TR_STEP,
    UOP_PATH_RD,
    UOP_OUT
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       open_empty;
    logic       limit_hit;
    logic       scan_last;
    logic       cur_at_target;
    logic       nb_oob;
    logic       walk_ok;
    logic       dir_last;
    logic       trace_at_start;
    logic       sidx_ok;
  } dp_flags_t;

  // Column offset of each neighbor direction.
  function automatic logic [7:0] step_dx(input logic [2:0] d);
    logic [7:0] r;
    case (d)
      3'd0, 3'd1, 3'd2: r = OFS_POS;
      3'd3, 3'd4:       r = OFS_ZERO;
      default:          r = OFS_NEG;
    endcase
    return r;
  endfunction

  // Row offset of each neighbor direction.
  function automatic logic [7:0] step_dy(input logic [2:0] d);
    logic [7:0] r;
    case (d)
      3'd0, 3'd3, 3'd5: r = OFS_POS;
      3'd1, 3'd6:       r = OFS_ZERO;
      default:          r = OFS_NEG;
    endcase
    return r;
  endfunction

  function automatic logic is_diag(input logic [2:0] d);
    return (d == 3'd0) || (d == 3'd2) || (d == 3'd5) || (d == 3'd7);
  endfunction

  // Octile distance between two cells.
  function automatic logic [HW-1:0] octile(input logic [XW-1:0] ax, input logic [XW-1:0] ay,
                                           input logic [XW-1:0] bx, input logic [XW-1:0] by);
    logic [XW-1:0] ddx;
    logic [XW-1:0] ddy;
    logic [XW-1:0] mn;
    logic [XW-1:0] mx;
    ddx = (ax > bx) ? ax - bx : bx - ax;
    ddy = (ay > by) ? ay - by : by - ay;
    mn  = (ddx > ddy) ? ddy : ddx;
    mx  = (ddx > ddy) ? ddx : ddy;
    return HW'(COST_DIAG * HW'(mn)) + HW'(COST_STRAIGHT * HW'(mx - mn));
  endfunction

endpackage

// ===== rtl/gasp_dp.sv =====
// ----------------------------------------------------------------------------
// gasp_dp
// Datapath: map, node tables, open list and path memories, with the counters
// and compare logic that the controller steps through.
// ----------------------------------------------------------------------------
module gasp_dp import gasp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  in_item_t     in_data,
  input  logic         cfg_wr_en,
  input  logic [LW-1:0] cfg_wr_data,
  input  dp_cmd_t      cmd,
  output dp_flags_t    flags,
  output out_item_t    out_data
);

  // Memories.
  logic          walk_mem [CELLS];
  logic [1:0]    stat_mem [CELLS];
  logic [GW-1:0] g_mem    [CELLS];
  logic [HW-1:0] h_mem    [CELLS];
  logic [2:0]    par_mem  [CELLS];
  logic [LW-1:0] st_mem   [CELLS];
  logic [IW-1:0] list_mem [CELLS];
  logic [IW-1:0] path_mem [CELLS];

  // Latched item and control registers.
  in_item_t      item_r;
  logic [LW-1:0] limit_r;
  logic [IW-1:0] clr_r;
  logic [LW-1:0] iters_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] open_cnt_r;
  logic [LW-1:0] stamp_r;
  logic [LW-1:0] k_r;
  logic          best_vld_r;

  // Payload registers.
  logic [IW-1:0] best_k_r;
  logic [IW-1:0] best_idx_r;
  logic [GW-1:0] best_g_r;
  logic [FW-1:0] best_f_r;
  logic [HW-1:0] best_h_r;
  logic [LW-1:0] best_st_r;
  logic [IW-1:0] cur_r;
  logic [GW-1:0] cur_g_r;
  logic [2:0]    dir_r;
  logic          walk_rd_r;
  logic [1:0]    stat_rd_r;
  logic [GW-1:0] g_rd_r;
  logic [HW-1:0] h_rd_r;
  logic [2:0]    par_rd_r;
  logic [LW-1:0] st_rd_r;
  logic [IW-1:0] list_rd_r;
  logic [IW-1:0] path_rd_r;
  out_item_t     out_r;

  // Neighbor geometry.
  logic [XW-1:0] cx, cy, nx, ny;
  logic [7:0]    nxe, nye, pxe, pye;
  logic [IW-1:0] nb_idx, start_idx, tgt_idx;
  logic [GW-1:0] ng;
  logic [FW-1:0] f_rd;
  logic          better;
  logic          do_ins, do_upd;
  logic [LW-1:0] cnt_m1, path_addr;

  assign cx        = cur_r[XW-1:0];
  assign cy        = cur_r[IW-1:XW];
  assign nxe       = {2'b00, cx} + step_dx(dir_r);
  assign nye       = {2'b00, cy} + step_dy(dir_r);
  assign nx        = nxe[XW-1:0];
  assign ny        = nye[XW-1:0];
  assign nb_idx    = {ny, nx};
  assign start_idx = {item_r.cell_y, item_r.cell_x};
  assign tgt_idx   = {item_r.target_y, item_r.target_x};
  assign ng        = cur_g_r + GW'(is_diag(dir_r) ? COST_DIAG : COST_STRAIGHT);
  assign pxe       = {2'b00, cx} - step_dx(par_rd_r);
  assign pye       = {2'b00, cy} - step_dy(par_rd_r);
  assign cnt_m1    = open_cnt_r - LW'(1);
  assign path_addr = len_r - LW'(1) - {1'b0, item_r.step_index};

  // Open list ordering: lower f, then lower h, then newer insertion.
  assign f_rd   = {1'b0, g_rd_r} + FW'(h_rd_r);
  assign better = !best_vld_r || (f_rd < best_f_r) ||
                  ((f_rd == best_f_r) && ((h_rd_r < best_h_r) ||
                   ((h_rd_r == best_h_r) && (st_rd_r > best_st_r))));

  assign do_ins = (cmd.uop == UOP_NB_ACT) && (stat_rd_r == NS_NONE);
  assign do_upd = (cmd.uop == UOP_NB_ACT) && (stat_rd_r == NS_OPEN) && (ng < g_rd_r);

  // Status back to the controller.
  always_comb begin
    flags.op             = item_r.op;
    flags.clr_last       = (clr_r == IW'(CELLS - 1));
    flags.open_empty     = (open_cnt_r == '0);
    flags.limit_hit      = (iters_r >= limit_r);
    flags.scan_last      = ((k_r + LW'(1)) == open_cnt_r);
    flags.cur_at_target  = (cur_r == tgt_idx);
    flags.nb_oob         = (nxe[7:XW] != 2'b00) || (nye[7:XW] != 2'b00);
    flags.walk_ok        = walk_rd_r;
    flags.dir_last       = (dir_r == 3'd7);
    flags.trace_at_start = (cur_r == start_idx);
    flags.sidx_ok        = ({1'b0, item_r.step_index} < len_r);
  end

  // Walkability map.
  logic          walk_we, walk_wd;
  logic [IW-1:0] walk_wa, walk_ra;
  always_comb begin
    walk_we = 1'b0;
    walk_wd = 1'b0;
    walk_wa = clr_r;
    case (cmd.uop)
      UOP_CLR_MAP: walk_we = 1'b1;
      UOP_MAP_WR: begin
        walk_we = 1'b1;
        walk_wd = item_r.walkable;
        walk_wa = start_idx;
      end
      default: ;
    endcase
    case (cmd.uop)
      UOP_NB_RD1: walk_ra = {cy, nx};
      UOP_NB_RD2: walk_ra = {ny, cx};
      default:    walk_ra = nb_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_rd_r <= walk_mem[walk_ra];
  end

  // Node status table.
  logic          stat_we;
  logic [1:0]    stat_wd;
  logic [IW-1:0] stat_wa;
  always_comb begin
    stat_we = 1'b1;
    stat_wd = NS_OPEN;
    stat_wa = nb_idx;
    case (cmd.uop)
      UOP_CLR_STAT: begin
        stat_wd = NS_NONE;
        stat_wa = clr_r;
      end
      UOP_INS_START: stat_wa = start_idx;
      UOP_POP_WR: begin
        stat_wd = NS_CLOSED;
        stat_wa = best_idx_r;
      end
      default: stat_we = do_ins;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    stat_rd_r <= stat_mem[nb_idx];
  end

  // Cost, heuristic, parent and stamp tables share one write address.
  logic          node_ins;
  logic [IW-1:0] node_wa, g_ra;
  assign node_ins = (cmd.uop == UOP_INS_START) || do_ins;
  assign node_wa  = (cmd.uop == UOP_INS_START) ? start_idx : nb_idx;
  assign g_ra     = (cmd.uop == UOP_SCAN_RD_NODE) ? list_rd_r : nb_idx;

  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_INS_START) begin
      g_mem[node_wa]   <= '0;
      h_mem[node_wa]   <= octile(item_r.cell_x, item_r.cell_y,
                                 item_r.target_x, item_r.target_y);
      par_mem[node_wa] <= '0;
      st_mem[node_wa]  <= '0;
    end else if (node_ins) begin
      g_mem[node_wa]   <= ng;
      h_mem[node_wa]   <= octile(nx, ny, item_r.target_x, item_r.target_y);
      par_mem[node_wa] <= dir_r;
      st_mem[node_wa]  <= stamp_r;
    end else if (do_upd) begin
      g_mem[node_wa]   <= ng;
      par_mem[node_wa] <= dir_r;
    end
    g_rd_r   <= g_mem[g_ra];
    h_rd_r   <= h_mem[list_rd_r];
    st_rd_r  <= st_mem[list_rd_r];
    par_rd_r <= par_mem[cur_r];
  end

  // Open list.
  logic          list_we;
  logic [IW-1:0] list_wa, list_wd, list_ra;
  always_comb begin
    list_we = 1'b1;
    list_wa = open_cnt_r[IW-1:0];
    list_wd = nb_idx;
    case (cmd.uop)
      UOP_INS_START: begin
        list_wa = '0;
        list_wd = start_idx;
      end
      UOP_POP_WR: begin
        list_wa = best_k_r;
        list_wd = list_rd_r;
      end
      default: list_we = do_ins;
    endcase
    list_ra = (cmd.uop == UOP_POP_RD) ? cnt_m1[IW-1:0] : k_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    if ((cmd.uop == UOP_SCAN_RD_LIST) || (cmd.uop == UOP_POP_RD)) begin
      list_rd_r <= list_mem[list_ra];
    end
  end

  // Path store, written from the target backward and read mirrored.
  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_TR_WR) path_mem[len_r[IW-1:0]] <= cur_r;
    path_rd_r <= path_mem[path_addr[IW-1:0]];
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RST;
      clr_r      <= '0;
      iters_r    <= '0;
      len_r      <= '0;
      open_cnt_r <= '0;
      stamp_r    <= '0;
      k_r        <= '0;
      best_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      case (cmd.uop)
        UOP_CLR_MAP, UOP_CLR_STAT: clr_r <= clr_r + IW'(1);
        UOP_SRCH_INIT: begin
          clr_r      <= '0;
          iters_r    <= '0;
          len_r      <= '0;
          open_cnt_r <= '0;
          stamp_r    <= '0;
        end
        UOP_INS_START: begin
          open_cnt_r <= LW'(1);
          stamp_r    <= LW'(1);
        end
        UOP_SCAN_INIT: begin
          k_r        <= '0;
          best_vld_r <= 1'b0;
        end
        UOP_SCAN_CMP: begin
          k_r        <= k_r + LW'(1);
          best_vld_r <= 1'b1;
        end
        UOP_POP_WR:   open_cnt_r <= cnt_m1;
        UOP_ITER_INC: iters_r <= iters_r + LW'(1);
        UOP_TR_WR:    len_r <= len_r + LW'(1);
        UOP_NB_ACT: begin
          if (do_ins) begin
            open_cnt_r <= open_cnt_r + LW'(1);
            stamp_r    <= stamp_r + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the search.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_LATCH: item_r <= in_data;
      UOP_SCAN_CMP: begin
        if (better) begin
          best_k_r   <= k_r[IW-1:0];
          best_idx_r <= list_rd_r;
          best_g_r   <= g_rd_r;
          best_f_r   <= f_rd;
          best_h_r   <= h_rd_r;
          best_st_r  <= st_rd_r;
        end
      end
      UOP_POP_WR: begin
        cur_r   <= best_idx_r;
        cur_g_r <= best_g_r;
        dir_r   <= '0;
      end
      UOP_NB_ACT, UOP_NB_SKIP: dir_r <= dir_r + 3'd1;
      UOP_TR_STEP: cur_r <= {pye[XW-1:0], pxe[XW-1:0]};
      UOP_OUT: begin
        out_r.status          <= cmd.res_status;
        out_r.path_length     <= len_r;
        out_r.iterations_used <= iters_r;
        if ((item_r.op == OP_READ) && (cmd.res_status == RS_DONE)) begin
          out_r.step_x <= path_rd_r[XW-1:0];
          out_r.step_y <= path_rd_r[IW-1:XW];
        end else begin
          out_r.step_x <= '0;
          out_r.step_y <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

`ifndef ASSERT_OFF
  // The open list never holds more nodes than were ever inserted.
  a_cnt_le_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= stamp_r)
    else $error("open list count exceeds insertions");

  // A scan compare always looks at a live open list entry.
  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == UOP_SCAN_CMP) |-> (k_r < open_cnt_r))
    else $error("scan index beyond open list");

  // A node is only removed from a non-empty open list.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == UOP_POP_WR) |-> (open_cnt_r != '0))
    else $error("pop from empty open list");

  // The stored path length counts up by one per traced cell.
  a_trace_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == UOP_TR_WR) |=> (len_r == $past(len_r) + LW'(1)))
    else $error("path length did not advance");
`endif

endmodule

// ===== rtl/gasp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gasp_ctrl
// Controller: sequences map writes, path reads and the search loop, and runs
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module gasp_ctrl import gasp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_CLR, S_START, S_LOOP, S_RDL, S_RDN, S_CMP,
    S_POPR, S_POPW, S_CHK, S_N1, S_N2, S_N3, S_N4, S_N5, S_ITER, S_TRW,
    S_TRS, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] res_r, res_nxt;
  logic       out_valid_r;
  logic       out_free;
  uop_t       uop;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.uop        = uop;
  assign cmd.res_status = res_r;

  // Next state and micro-operation.
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    uop       = UOP_NONE;
    case (state_r)
      S_INIT: begin
        uop = UOP_CLR_MAP;
        if (flags.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          uop       = UOP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt   = RS_DONE;
        state_nxt = S_OUT;
        case (flags.op)
          OP_WRITE: uop = UOP_MAP_WR;
          OP_SEARCH: begin
            uop       = UOP_SRCH_INIT;
            state_nxt = S_CLR;
          end
          OP_READ: begin
            uop     = UOP_PATH_RD;
            res_nxt = flags.sidx_ok ? RS_DONE : RS_RANGE;
          end
          default: ;
        endcase
      end
      S_CLR: begin
        uop = UOP_CLR_STAT;
        if (flags.clr_last) state_nxt = S_START;
      end
      S_START: begin
        uop       = UOP_INS_START;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        uop = UOP_SCAN_INIT;
        if (flags.open_empty || flags.limit_hit) begin
          res_nxt   = RS_NOPATH;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        uop       = UOP_SCAN_RD_LIST;
        state_nxt = S_RDN;
      end
      S_RDN: begin
        uop       = UOP_SCAN_RD_NODE;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        uop       = UOP_SCAN_CMP;
        state_nxt = flags.scan_last ? S_POPR : S_RDL;
      end
      S_POPR: begin
        uop       = UOP_POP_RD;
        state_nxt = S_POPW;
      end
      S_POPW: begin
        uop       = UOP_POP_WR;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = flags.cur_at_target ? S_TRW : S_N1;
      end
      S_N1: begin
        if (flags.nb_oob) begin
          uop       = UOP_NB_SKIP;
          state_nxt = flags.dir_last ? S_ITER : S_N1;
        end else begin
          uop       = UOP_NB_RD1;
          state_nxt = S_N2;
        end
      end
      S_N2, S_N3, S_N4: begin
        if (!flags.walk_ok) begin
          uop       = UOP_NB_SKIP;
          state_nxt = flags.dir_last ? S_ITER : S_N1;
        end else if (state_r == S_N2) begin
          uop       = UOP_NB_RD2;
          state_nxt = S_N3;
        end else if (state_r == S_N3) begin
          uop       = UOP_NB_RD3;
          state_nxt = S_N4;
        end else begin
          uop       = UOP_NB_RD4;
          state_nxt = S_N5;
        end
      end
      S_N5: begin
        uop       = UOP_NB_ACT;
        state_nxt = flags.dir_last ? S_ITER : S_N1;
      end
      S_ITER: begin
        uop       = UOP_ITER_INC;
        state_nxt = S_LOOP;
      end
      S_TRW: begin
        uop = UOP_TR_WR;
        if (flags.trace_at_start) begin
          res_nxt   = RS_FOUND;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_TRS;
        end
      end
      S_TRS: begin
        uop       = UOP_TR_STEP;
        state_nxt = S_TRW;
      end
      S_OUT: begin
        if (out_free) begin
          uop       = UOP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, result code and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      res_r       <= RS_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      if (uop == UOP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // A result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uop == UOP_OUT) |-> out_free)
    else $error("result overwrote a pending transfer");

  // Every item leaves the idle state for dispatch.
  a_latch_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (uop == UOP_LATCH) |=> (state_r == S_DISP))
    else $error("accepted item not dispatched");

  // A search result reports found only after a traced start cell.
  a_found_trace: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(res_r == RS_FOUND)) |-> ($past(state_r) == S_TRW))
    else $error("path found without trace");
`endif

endmodule

// ===== rtl/grid_astar_path_search_top.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search with octile costs over a 64 x 64 walkability map.
// ----------------------------------------------------------------------------
// After reset the block clears the map to blocked and takes no item
// meanwhile. A map write or a path read goes from dispatch to the output
// state, which loads the result register once it is free and returns to
// idle for the next item. A search first clears the node table. Each
// expansion then starts the open list scan, reads the list entry and node
// data of each open node and compares them, removes the best node and checks
// it against the target, checks each neighbor direction (one read of the
// single map port per check) and counts the expansion; a found path is
// traced back cell by cell. The open list scan dominates long searches. One
// item is worked on at a time; a finished result waits in the output register
// while the next item is taken.
module grid_astar_path_search_top import gasp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  input  logic          cfg_wr_en,
  input  logic [LW-1:0] cfg_wr_data
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  gasp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  gasp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .flags       (flags),
    .out_data    (out_data)
  );

endmodule
